@@ hw/rtl/sha1sh_pkg.sv @@
// Shared types, constants and state encodings of the SHA-1 stream hasher.
`timescale 1ns / 1ps

package sha1sh_pkg;

	localparam int DIGEST_WORDS = 5;
	localparam int WQ_DEPTH     = 16;
	localparam int WQ_AW        = $clog2(WQ_DEPTH);
	localparam int ROUNDS       = 80;
	localparam int RND_W        = $clog2(ROUNDS);

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	typedef logic [DIGEST_WORDS-1:0][31:0] digest_t;

	// element 0 is H0
	localparam digest_t SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] POS_LEN   = 6'd56;  // 448 bits: length field starts here
	localparam logic [5:0] POS_LAST  = 6'd63;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// one big-endian message word on its way to the compression engine
	typedef struct packed {
		logic        final_word;
		logic [31:0] word;
	} wq_entry_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_PAD80,
		FS_ZERO,
		FS_LEN
	} front_state_t;

	typedef enum logic [1:0] {
		CS_ROUND,
		CS_UPDATE,
		CS_EMIT
	} core_state_t;

endpackage

@@ hw/rtl/sha1sh_front.sv @@
// Front end: takes input items, packs bytes into words, appends padding and length.
`timescale 1ns / 1ps

module sha1sh_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1sh_pkg::in_item_t byte_item,
	input  logic                 push,
	output logic                 full,
	output sha1sh_pkg::wq_entry_t wq_entry,
	output logic                 wq_push,
	input  logic                 wq_full
);

	sha1sh_pkg::front_state_t state_q, state_nx;
	logic [5:0]  pos_q;
	logic [63:0] bit_len_q;
	logic [23:0] acc_q;

	logic       accept;
	logic       msg_step;
	logic       pad_step;
	logic       byte_en;
	logic [7:0] byte_val;
	logic [7:0] len_byte;

	assign accept   = push && !full;
	assign msg_step = accept && byte_item.byte_valid;
	// length goes out most significant byte first
	assign len_byte = 8'(bit_len_q >> {~pos_q[2:0], 3'b000});

	// outputs of the sequencer
	always_comb begin
		full     = 1'b1;
		pad_step = 1'b0;
		byte_val = 8'h00;
		case (state_q)
			sha1sh_pkg::FS_IDLE: begin
				full     = wq_full;
				byte_val = byte_item.data_byte;
			end
			sha1sh_pkg::FS_PAD80: begin
				pad_step = !wq_full;
				byte_val = sha1sh_pkg::PAD_MARK;
			end
			sha1sh_pkg::FS_ZERO: begin
				pad_step = !wq_full;
			end
			sha1sh_pkg::FS_LEN: begin
				pad_step = !wq_full;
				byte_val = len_byte;
			end
			default: begin
				full = 1'b1;
			end
		endcase
	end

	assign byte_en = msg_step || pad_step;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			sha1sh_pkg::FS_IDLE: begin
				if (accept && byte_item.last_of_message)
					state_nx = sha1sh_pkg::FS_PAD80;
			end
			sha1sh_pkg::FS_PAD80: begin
				if (pad_step)
					state_nx = (pos_q == sha1sh_pkg::POS_LEN - 6'd1) ?
						sha1sh_pkg::FS_LEN : sha1sh_pkg::FS_ZERO;
			end
			sha1sh_pkg::FS_ZERO: begin
				if (pad_step && pos_q == sha1sh_pkg::POS_LEN - 6'd1)
					state_nx = sha1sh_pkg::FS_LEN;
			end
			sha1sh_pkg::FS_LEN: begin
				if (pad_step && pos_q == sha1sh_pkg::POS_LAST)
					state_nx = sha1sh_pkg::FS_IDLE;
			end
			default: begin
				state_nx = sha1sh_pkg::FS_IDLE;
			end
		endcase
	end

	assign wq_push             = byte_en && (pos_q[1:0] == 2'd3);
	assign wq_entry.word       = {acc_q, byte_val};
	assign wq_entry.final_word = (state_q == sha1sh_pkg::FS_LEN) &&
		(pos_q == sha1sh_pkg::POS_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sha1sh_pkg::FS_IDLE;
			pos_q     <= '0;
			bit_len_q <= '0;
		end else begin
			state_q <= state_nx;
			if (byte_en)
				pos_q <= pos_q + 6'd1;
			if (msg_step)
				bit_len_q <= bit_len_q + 64'd8;
			else if (wq_push && wq_entry.final_word)
				bit_len_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en)
			acc_q <= {acc_q[15:0], byte_val};
	end

endmodule

@@ hw/rtl/sha1sh_wfifo.sv @@
// Word queue between the front end and the compression engine.
`timescale 1ns / 1ps

module sha1sh_wfifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1sh_pkg::wq_entry_t wr_entry,
	input  logic                  wr_en,
	output logic                  wq_full,
	output sha1sh_pkg::wq_entry_t rd_entry,
	input  logic                  rd_en,
	output logic                  wq_empty
);

	sha1sh_pkg::wq_entry_t mem_q [sha1sh_pkg::WQ_DEPTH];
	logic [sha1sh_pkg::WQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [sha1sh_pkg::WQ_AW:0]   count_q;
	logic do_wr, do_rd;

	assign wq_full  = (count_q == (sha1sh_pkg::WQ_AW+1)'(sha1sh_pkg::WQ_DEPTH));
	assign wq_empty = (count_q == '0);
	assign do_wr    = wr_en && !wq_full;
	assign do_rd    = rd_en && !wq_empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_entry;
	end

endmodule

@@ hw/rtl/sha1sh_core.sv @@
// Compression engine: one SHA-1 round per cycle unless waiting on the word queue, schedule in a 16-word shift line.
`timescale 1ns / 1ps

module sha1sh_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1sh_pkg::wq_entry_t wq_entry,
	input  logic                  wq_empty,
	output logic                  wq_pop,
	output sha1sh_pkg::digest_t   digest,
	output logic                  dig_load,
	input  logic                  dig_busy
);

	sha1sh_pkg::core_state_t state_q, state_nx;
	sha1sh_pkg::digest_t h_q;
	sha1sh_pkg::digest_t work_q;   // a..e in elements 0..4
	logic [31:0] w_q [16];         // w_q[15] is the newest word
	logic [sha1sh_pkg::RND_W-1:0] rnd_q;
	logic final_q;

	logic        round_go;
	logic        early;
	logic [31:0] w_mix, w_cur, f, k, t;
	logic [31:0] a, b, c, d, e;
	sha1sh_pkg::digest_t h_sum;

	assign a = work_q[0];
	assign b = work_q[1];
	assign c = work_q[2];
	assign d = work_q[3];
	assign e = work_q[4];

	assign early = (rnd_q < sha1sh_pkg::RND_W'(16));
	assign w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_cur = early ? wq_entry.word : {w_mix[30:0], w_mix[31]};

	always_comb begin
		if (rnd_q < sha1sh_pkg::RND_W'(20)) begin
			f = (b & c) | (~b & d);
			k = sha1sh_pkg::K_R0;
		end else if (rnd_q < sha1sh_pkg::RND_W'(40)) begin
			f = b ^ c ^ d;
			k = sha1sh_pkg::K_R1;
		end else if (rnd_q < sha1sh_pkg::RND_W'(60)) begin
			f = (b & c) | (b & d) | (c & d);
			k = sha1sh_pkg::K_R2;
		end else begin
			f = b ^ c ^ d;
			k = sha1sh_pkg::K_R3;
		end
	end

	assign t = {a[26:0], a[31:27]} + f + e + k + w_cur;

	always_comb begin
		for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++)
			h_sum[i] = h_q[i] + work_q[i];
	end

	assign digest = h_q;

	// sequencer outputs
	always_comb begin
		round_go = 1'b0;
		wq_pop   = 1'b0;
		dig_load = 1'b0;
		case (state_q)
			sha1sh_pkg::CS_ROUND: begin
				round_go = !early || !wq_empty;
				wq_pop   = early && !wq_empty;
			end
			sha1sh_pkg::CS_EMIT: begin
				dig_load = !dig_busy;
			end
			default: begin
				round_go = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			sha1sh_pkg::CS_ROUND: begin
				if (round_go && rnd_q == sha1sh_pkg::RND_W'(sha1sh_pkg::ROUNDS - 1))
					state_nx = sha1sh_pkg::CS_UPDATE;
			end
			sha1sh_pkg::CS_UPDATE: begin
				state_nx = final_q ? sha1sh_pkg::CS_EMIT : sha1sh_pkg::CS_ROUND;
			end
			sha1sh_pkg::CS_EMIT: begin
				if (dig_load)
					state_nx = sha1sh_pkg::CS_ROUND;
			end
			default: begin
				state_nx = sha1sh_pkg::CS_ROUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1sh_pkg::CS_ROUND;
			rnd_q   <= '0;
			final_q <= 1'b0;
			h_q     <= sha1sh_pkg::SHA1_IV;
			work_q  <= sha1sh_pkg::SHA1_IV;
		end else begin
			state_q <= state_nx;
			if (round_go) begin
				work_q <= {d, c, {b[1:0], b[31:2]}, a, t};
				if (rnd_q == sha1sh_pkg::RND_W'(sha1sh_pkg::ROUNDS - 1))
					rnd_q <= '0;
				else
					rnd_q <= rnd_q + 1'b1;
				if (wq_pop && wq_entry.final_word)
					final_q <= 1'b1;
			end
			if (state_q == sha1sh_pkg::CS_UPDATE) begin
				h_q    <= h_sum;
				work_q <= h_sum;
			end
			if (dig_load) begin
				h_q     <= sha1sh_pkg::SHA1_IV;
				work_q  <= sha1sh_pkg::SHA1_IV;
				final_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (round_go) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= w_cur;
		end
	end

endmodule

@@ hw/rtl/sha1sh_dout.sv @@
// Digest output stage: holds one finished digest and hands it out word by word.
`timescale 1ns / 1ps

module sha1sh_dout (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha1sh_pkg::digest_t    digest,
	input  logic                   dig_load,
	output logic                   dig_busy,
	output sha1sh_pkg::out_item_t  digest_item,
	output logic                   empty,
	input  logic                   pop
);

	sha1sh_pkg::digest_t words_q;
	logic [2:0] idx_q;
	logic       valid_q;
	logic       take;

	assign dig_busy = valid_q;
	assign empty    = !valid_q;
	assign take     = pop && valid_q;

	assign digest_item.digest_word = words_q[0];
	assign digest_item.word_index  = idx_q;
	assign digest_item.last_word   = (idx_q == 3'(sha1sh_pkg::DIGEST_WORDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (dig_load && !valid_q) begin
				valid_q <= 1'b1;
				idx_q   <= '0;
			end else if (take) begin
				idx_q <= idx_q + 3'd1;
				if (digest_item.last_word)
					valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dig_load && !valid_q)
			words_q <= digest;
		else if (take)
			words_q <= {32'h0, words_q[sha1sh_pkg::DIGEST_WORDS-1:1]};
	end

endmodule

@@ hw/rtl/sha1_stream_hasher.sv @@
// Top level of the SHA-1 stream hasher: front end, word queue, engine, digest output.
//
// Usage:
//  - Input channel (push/full): one item per accepted edge carries an optional
//    message byte (byte_valid) and an end-of-message mark (last_of_message).
//    An item with neither bit set is taken and ignored. An empty message is a
//    single item with only last_of_message set.
//  - Bytes are taken one per cycle while the word queue has room. After a
//    last item, full stays high while the front end appends 0x80, zero fill
//    and the 64-bit big-endian bit count.
//  - The engine runs one round per cycle while it has words, 80 rounds plus
//    an update step per 64-byte block; rounds 0 to 15 take their words
//    straight from the queue and wait while it is empty. The next block
//    fills the 16-word queue while the current one compresses.
//  - Result channel (empty/pop): five items per message, digest word 0 first,
//    last_word set on word 4. The first word follows the final round via the
//    update and emit states. While the receiver stalls, the engine keeps
//    compressing the next message and only waits once that message's digest is also ready.
//  - Reset (arst_n low) drops any partial message, empties both queues and
//    restores the initial chaining value.
`timescale 1ns / 1ps

module sha1_stream_hasher (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha1sh_pkg::in_item_t   byte_item,
	input  logic                   push,
	output logic                   full,
	output sha1sh_pkg::out_item_t  digest_item,
	output logic                   empty,
	input  logic                   pop
);

	sha1sh_pkg::wq_entry_t wq_wr_entry, wq_rd_entry;
	sha1sh_pkg::digest_t   digest;
	logic wq_push, wq_full, wq_pop, wq_empty;
	logic dig_load, dig_busy;

	// byte packing and padding
	sha1sh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_item (byte_item),
		.push      (push),
		.full      (full),
		.wq_entry  (wq_wr_entry),
		.wq_push   (wq_push),
		.wq_full   (wq_full)
	);

	// decouples byte intake from the round loop
	sha1sh_wfifo u_wfifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_entry (wq_wr_entry),
		.wr_en    (wq_push),
		.wq_full  (wq_full),
		.rd_entry (wq_rd_entry),
		.rd_en    (wq_pop),
		.wq_empty (wq_empty)
	);

	// 80-round compression and chaining value
	sha1sh_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.wq_entry (wq_rd_entry),
		.wq_empty (wq_empty),
		.wq_pop   (wq_pop),
		.digest   (digest),
		.dig_load (dig_load),
		.dig_busy (dig_busy)
	);

	// finished digest, handed out one word per item
	sha1sh_dout u_dout (
		.clk         (clk),
		.arst_n      (arst_n),
		.digest      (digest),
		.dig_load    (dig_load),
		.dig_busy    (dig_busy),
		.digest_item (digest_item),
		.empty       (empty),
		.pop         (pop)
	);

	// front end never writes into a full queue; it gates every byte on room
	a_no_wq_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wq_push |-> !wq_full)
		else $error("word queue written while full");

	// engine only reads a word that is there
	a_no_wq_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		wq_pop |-> !wq_empty)
		else $error("word queue read while empty");

	// a new digest is only handed over once the previous one has fully gone
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		dig_load |-> empty)
		else $error("digest handed over while output busy");

	// taking the fifth word frees the output stage on the next cycle
	a_last_word_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && digest_item.last_word) |=> empty)
		else $error("output stage still busy after last digest word");

endmodule

@@ test/sha1_digest_checker.sv @@
// Digest checker for the SHA-1 stream hasher: predicts digest words from items and compares.
`timescale 1ns / 1ps

module sha1_digest_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1sh_pkg::in_item_t  byte_item,
	input  logic                  push,
	input  logic                  full,
	input  sha1sh_pkg::out_item_t digest_item,
	input  logic                  empty,
	input  logic                  pop,
	output int                    fail_count,
	output int                    words_due,
	output int                    words_checked
);

	logic [31:0] chain_h [sha1sh_pkg::DIGEST_WORDS];
	logic [7:0]  blk [64];
	int unsigned blk_fill;
	logic [63:0] msg_bits;
	sha1sh_pkg::out_item_t digest_words_due [$];
	sha1sh_pkg::out_item_t want;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < 80; r++) begin
			// rolling 16-word schedule
			if (r >= 16)
				w[r % 16] = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16]
					^ w[(r + 2) % 16] ^ w[r % 16], 1);
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = sha1sh_pkg::K_R0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = sha1sh_pkg::K_R1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1sh_pkg::K_R2;
			end else begin
				f = b ^ c ^ d;
				k = sha1sh_pkg::K_R3;
			end
			t = rotl(a, 5) + f + e + k + w[r % 16];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endtask

	task automatic take_byte(input logic [7:0] v);
		blk[blk_fill] = v;
		blk_fill++;
		if (blk_fill == 64) begin
			compress_block();
			blk_fill = 0;
		end
	endtask

	task automatic restart();
		for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++)
			chain_h[i] = sha1sh_pkg::SHA1_IV[i];
		blk_fill = 0;
		msg_bits = '0;
	endtask

	// pad mark, zero fill up to the length field, 64-bit length, then queue the digest
	task automatic close_message();
		logic [63:0] len;
		sha1sh_pkg::out_item_t word;
		len = msg_bits;
		take_byte(sha1sh_pkg::PAD_MARK);
		while (blk_fill != sha1sh_pkg::POS_LEN)
			take_byte(8'h00);
		for (int i = 7; i >= 0; i--)
			take_byte(len[8*i +: 8]);
		for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) begin
			word.digest_word = chain_h[i];
			word.word_index  = 3'(i);
			word.last_word   = (i == sha1sh_pkg::DIGEST_WORDS - 1);
			digest_words_due.push_back(word);
		end
		restart();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart();
			digest_words_due.delete();
			fail_count    = 0;
			words_checked = 0;
		end else begin
			if (push && !full) begin
				if (byte_item.byte_valid) begin
					take_byte(byte_item.data_byte);
					msg_bits += 64'd8;
				end
				if (byte_item.last_of_message)
					close_message();
			end
			if (pop && !empty) begin
				if (digest_words_due.size() == 0) begin
					$display("%0t: unexpected digest item %h", $time, digest_item);
					fail_count++;
				end else begin
					want = digest_words_due.pop_front();
					if (digest_item.digest_word !== want.digest_word) begin
						$display("%0t: digest_word expected %h, got %h", $time,
							want.digest_word, digest_item.digest_word);
						fail_count++;
					end
					if (digest_item.word_index !== want.word_index) begin
						$display("%0t: word_index expected %0d, got %0d", $time,
							want.word_index, digest_item.word_index);
						fail_count++;
					end
					if (digest_item.last_word !== want.last_word) begin
						$display("%0t: last_word expected %b, got %b", $time,
							want.last_word, digest_item.last_word);
						fail_count++;
					end
					words_checked++;
				end
			end
		end
		words_due = digest_words_due.size();
	end

endmodule

@@ test/sha1_stream_hasher_tb.sv @@
// Testbench top for the SHA-1 stream hasher: clock, reset, byte stimulus, digest drain and verdict.
`timescale 1ns / 1ps

module sha1_stream_hasher_tb;

	logic                  clk;
	logic                  arst_n;
	sha1sh_pkg::in_item_t  byte_item;
	logic                  push;
	logic                  full;
	sha1sh_pkg::out_item_t digest_item;
	logic                  empty;
	logic                  pop;

	int fail_count;
	int words_due;
	int words_checked;

	// stimulus bookkeeping for the closing summary and the stop condition, plus the sender's calm flag
	int items_sent;
	int bytes_sent;
	int messages_sent;
	int idles_sent;
	bit sender_calm;

	sha1_stream_hasher uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_item   (byte_item),
		.push        (push),
		.full        (full),
		.digest_item (digest_item),
		.empty       (empty),
		.pop         (pop)
	);

	sha1_digest_checker digest_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_item     (byte_item),
		.push          (push),
		.full          (full),
		.digest_item   (digest_item),
		.empty         (empty),
		.pop           (pop),
		.fail_count    (fail_count),
		.words_due     (words_due),
		.words_checked (words_checked)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mostly no gap or a short one, now and then a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Message lengths: mostly short, a good share straddling the 55/56 and
	// 63/64 byte padding boundaries, some middling and a few of 100 to 130 bytes.
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(0, 10);
		else if (r < 82)
			return $urandom_range(52, 68);
		else if (r < 95)
			return $urandom_range(11, 40);
		else
			return $urandom_range(100, 130);
	endfunction

	// One item on the push side. push stays high straight into the next item
	// when there is no gap, so it never sees a low and a high in one step.
	task automatic send_item(input logic [7:0] d, input logic v, input logic l);
		int                   gap;
		sha1sh_pkg::in_item_t it;
		gap = sender_calm ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.data_byte       = d;
		it.byte_valid      = v;
		it.last_of_message = l;
		byte_item <= it;
		push      <= 1'b1;
		do @(posedge clk); while (full);
		if (v || l)
			items_sent++;
		else
			idles_sent++;
		if (v)
			bytes_sent++;
		if (l)
			messages_sent++;
	endtask

	// A whole message of random bytes. The last byte either rides on the
	// closing item or the close comes as a separate item with junk data.
	// Ignored items are sprinkled in as noise.
	task automatic send_message(input int n, input bit last_with_byte);
		sender_calm = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, (i == n - 1) && last_with_byte);
		end
		if (n == 0 || !last_with_byte)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		arst_n      = 1'b0;
		push        = 1'b0;
		byte_item   = '0;
		sender_calm = 1'b0;
		items_sent    = 0;
		bytes_sent    = 0;
		messages_sent = 0;
		idles_sent    = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		// empty message straight after reset
		send_item(8'h00, 1'b0, 1'b1);
		// ignored item with all data bits set
		send_item(8'hFF, 1'b0, 1'b0);
		// "abc", closed by a separate item carrying junk data
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b0);
		send_item(8'hA5, 1'b0, 1'b1);
		// byte extremes, last byte riding on the closing item
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b1);
		// one-byte message in a single item
		send_item(8'hFF, 1'b1, 1'b1);
		// ignored item, then empty message again with junk data
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);

		// --- random part ---
		// padding boundaries first: length field fits, needs an extra block,
		// and the block-full cases just before and at 64 bytes
		send_message(55, $urandom_range(0, 1));
		send_message(56, $urandom_range(0, 1));
		send_message(63, $urandom_range(0, 1));
		send_message(64, $urandom_range(0, 1));
		// the bit count wrapping at 2^64 is far beyond reach in simulation
		while (items_sent + idles_sent < 410)
			send_message(pick_len(), $urandom_range(0, 1));
		push <= 1'b0;

		// drain: every predicted word back, then a quiet stretch for strays
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Run covered %0d messages, %0d message bytes and %0d ignored items,",
			messages_sent, bytes_sent, idles_sent);
		$display("with %0d digest words compared against the prediction.", words_checked);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Result side: random pop gaps with calm stretches, plus one long hold-off
	// early on so the engine backs up and full rises while bytes keep coming.
	initial begin : drain
		int gap;
		int popped;
		bit calm;
		pop    = 1'b0;
		popped = 0;
		calm   = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (popped == 30) begin
				pop <= 1'b0;
				repeat (700) @(posedge clk);
			end
			if ($urandom_range(0, 15) == 0)
				calm = !calm;
			gap = calm ? 0 : pick_gap();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			popped++;
		end
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
